>>> rtl/core/prs_pkg.sv
package prs_pkg;

	localparam int TAP_COUNT    = 32;
	localparam int PHASE_BITS   = 6;
	localparam int PHASE_COUNT  = 1 << PHASE_BITS;
	localparam int TAP_BITS     = $clog2(TAP_COUNT);
	localparam int COEF_DEPTH   = PHASE_COUNT * TAP_COUNT;
	localparam int COEF_AW      = $clog2(COEF_DEPTH);
	localparam int MAX_RESULTS  = 49;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

	localparam int OPCODE_W     = 2;
	localparam int SAMPLE_W     = 16;
	localparam int COEF_PHASE_W = 6;
	localparam int COEF_TAP_W   = 5;
	localparam int PROD_W       = 2 * SAMPLE_W;
	localparam int ACC_W        = PROD_W + TAP_BITS + 1;
	localparam int FRAC_SHIFT   = 15;
	localparam int SAMPLE_MAX   = 32767;
	localparam int SAMPLE_MIN   = -32768;

	localparam int PHASE_W      = 38;
	localparam int PHASE_FRAC   = 32;
	localparam logic [PHASE_W-1:0] PHASE_UNITY = PHASE_W'(64'd1 << PHASE_FRAC);
	localparam logic [PHASE_W-1:0] STEP_RESET  = PHASE_UNITY;
	localparam logic [PHASE_W-1:0] PHASE_MAX   = '1;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_COEF  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef struct packed {
		opcode_t                     op;
		logic signed [SAMPLE_W-1:0]  sample;
		logic [COEF_AW-1:0]          coef_addr;
		logic signed [SAMPLE_W-1:0]  coef_value;
	} cmd_t;

	typedef struct packed {
		logic [QUEUE_AW:0] count;
		logic              full;
	} queue_stat_t;

	typedef struct packed {
		logic busy;
		logic in_run;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} back_state_t;

endpackage

>>> rtl/core/prs_in_if.sv
interface prs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [prs_pkg::OPCODE_W-1:0]         opcode;
	logic signed [prs_pkg::SAMPLE_W-1:0]  sample_in;
	logic [prs_pkg::COEF_PHASE_W-1:0]     coef_phase;
	logic [prs_pkg::COEF_TAP_W-1:0]       coef_tap;
	logic signed [prs_pkg::SAMPLE_W-1:0]  coef_value;

	modport source (output valid, opcode, sample_in, coef_phase, coef_tap, coef_value,
		input ready);
	modport sink (input valid, opcode, sample_in, coef_phase, coef_tap, coef_value,
		output ready);
endinterface

>>> rtl/core/prs_out_if.sv
interface prs_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [prs_pkg::SAMPLE_W-1:0]  sample_out;
	logic                                 last_of_run;

	modport source (output valid, sample_out, last_of_run, input ready);
	modport sink (input valid, sample_out, last_of_run, output ready);
endinterface

>>> rtl/core/prs_front.sv
module prs_front (
	prs_in_if.sink          din,
	output logic            cmd_valid,
	output prs_pkg::cmd_t   cmd,
	input  logic            cmd_ready
);

	logic keep;

	// drop unused opcodes and out-of-range coefficient writes
	always_comb begin
		keep = 1'b0;
		unique case (prs_pkg::opcode_t'(din.opcode))
			prs_pkg::OP_PUSH:  keep = 1'b1;
			prs_pkg::OP_CLEAR: keep = 1'b1;
			prs_pkg::OP_COEF:  keep = (int'(din.coef_phase) < prs_pkg::PHASE_COUNT) &&
				(int'(din.coef_tap) < prs_pkg::TAP_COUNT);
			default:           keep = 1'b0;
		endcase
	end

	always_comb begin
		cmd.op         = prs_pkg::opcode_t'(din.opcode);
		cmd.sample     = din.sample_in;
		cmd.coef_addr  = prs_pkg::COEF_AW'(din.coef_phase) *
			prs_pkg::COEF_AW'(prs_pkg::TAP_COUNT) + prs_pkg::COEF_AW'(din.coef_tap);
		cmd.coef_value = din.coef_value;
	end

	assign cmd_valid = din.valid && keep;
	assign din.ready = cmd_ready;

endmodule

>>> rtl/core/prs_queue.sv
module prs_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_valid,
	input  prs_pkg::cmd_t          wr_data,
	output logic                   wr_ready,
	output logic                   rd_valid,
	output prs_pkg::cmd_t          rd_data,
	input  logic                   rd_ready,
	output prs_pkg::queue_stat_t   stat
);

	localparam logic [prs_pkg::QUEUE_AW:0]   FULL_CNT = (prs_pkg::QUEUE_AW + 1)'(prs_pkg::QUEUE_DEPTH);
	localparam logic [prs_pkg::QUEUE_AW-1:0] LAST_PTR = prs_pkg::QUEUE_AW'(prs_pkg::QUEUE_DEPTH - 1);

	prs_pkg::cmd_t                slot_q [prs_pkg::QUEUE_DEPTH];
	logic [prs_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [prs_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [prs_pkg::QUEUE_AW:0]   count_q;
	logic                         push;
	logic                         pop;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = slot_q[rd_ptr_q];

	assign stat.count = count_q;
	assign stat.full  = !wr_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/prs_back.sv
module prs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  prs_pkg::cmd_t                 cmd,
	output logic                          cmd_ready,
	input  logic [prs_pkg::PHASE_W-1:0]   phase_step,
	prs_out_if.source                     dout,
	output prs_pkg::back_stat_t           stat
);

	localparam logic [prs_pkg::TAP_BITS-1:0] LAST_TAP = prs_pkg::TAP_BITS'(prs_pkg::TAP_COUNT - 1);
	localparam logic [prs_pkg::CNT_W-1:0]    MAX_CNT  = prs_pkg::CNT_W'(prs_pkg::MAX_RESULTS);
	localparam logic [prs_pkg::CNT_W-1:0]    LAST_CNT = prs_pkg::CNT_W'(prs_pkg::MAX_RESULTS - 1);

	prs_pkg::back_state_t                 state_q, state_d;
	logic [prs_pkg::PHASE_W-1:0]          phase_q, phase_d;
	logic [prs_pkg::CNT_W-1:0]            count_q, count_d;
	logic [prs_pkg::TAP_BITS-1:0]         tap_q;
	logic [prs_pkg::PHASE_BITS-1:0]       row_q;
	logic signed [prs_pkg::SAMPLE_W-1:0]  history_q [prs_pkg::TAP_COUNT];
	logic signed [prs_pkg::SAMPLE_W-1:0]  coef_mem [prs_pkg::COEF_DEPTH];
	logic signed [prs_pkg::SAMPLE_W-1:0]  coef_s1;
	logic signed [prs_pkg::SAMPLE_W-1:0]  hist_s1;
	logic signed [prs_pkg::PROD_W-1:0]    prod_s2;
	logic                                 v_s1, v_s2;
	logic signed [prs_pkg::ACC_W-1:0]     acc_q;
	logic signed [prs_pkg::ACC_W-1:0]     acc_shr;
	logic                                 out_valid_q;
	logic signed [prs_pkg::SAMPLE_W-1:0]  out_sample_q;
	logic                                 out_last_q;
	logic signed [prs_pkg::SAMPLE_W-1:0]  sat_sample;

	logic [prs_pkg::COEF_AW-1:0]          rd_addr;
	logic [prs_pkg::PHASE_W:0]            phase_sum;
	logic [prs_pkg::PHASE_W-1:0]          phase_next;
	logic                                 out_free;
	logic                                 hist_push, hist_clr, coef_we;
	logic                                 run_start, issue, out_load, out_last;

	assign phase_sum  = {1'b0, phase_q} + {1'b0, phase_step};
	assign phase_next = phase_sum[prs_pkg::PHASE_W] ? prs_pkg::PHASE_MAX :
		phase_sum[prs_pkg::PHASE_W-1:0];
	assign out_free   = !out_valid_q || dout.ready;
	assign out_last   = (phase_next >= prs_pkg::PHASE_UNITY) || (count_q == LAST_CNT);
	assign rd_addr    = prs_pkg::COEF_AW'(row_q) * prs_pkg::COEF_AW'(prs_pkg::TAP_COUNT) +
		prs_pkg::COEF_AW'(tap_q);

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		count_d   = count_q;
		hist_push = 1'b0;
		hist_clr  = 1'b0;
		coef_we   = 1'b0;
		run_start = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			prs_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						prs_pkg::OP_PUSH: begin
							hist_push = 1'b1;
							count_d   = '0;
							state_d   = prs_pkg::ST_CHECK;
						end
						prs_pkg::OP_COEF: coef_we = 1'b1;
						prs_pkg::OP_CLEAR: begin
							hist_clr = 1'b1;
							phase_d  = '0;
						end
						default: ;
					endcase
				end
			end
			prs_pkg::ST_CHECK: begin
				if ((phase_q < prs_pkg::PHASE_UNITY) && (count_q < MAX_CNT)) begin
					run_start = 1'b1;
					state_d   = prs_pkg::ST_MAC;
				end else begin
					// cap reached with phase below one: leave the phase as is
					if (phase_q >= prs_pkg::PHASE_UNITY) begin
						phase_d = phase_q - prs_pkg::PHASE_UNITY;
					end
					state_d = prs_pkg::ST_IDLE;
				end
			end
			prs_pkg::ST_MAC: begin
				issue = 1'b1;
				if (tap_q == LAST_TAP) begin
					state_d = prs_pkg::ST_DRAIN;
				end
			end
			prs_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = prs_pkg::ST_OUT;
				end
			end
			prs_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					phase_d  = phase_next;
					count_d  = count_q + 1'b1;
					state_d  = prs_pkg::ST_CHECK;
				end
			end
			default: state_d = prs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prs_pkg::ST_IDLE;
			phase_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < prs_pkg::TAP_COUNT; i++) begin
				history_q[i] <= '0;
			end
		end else if (hist_clr) begin
			for (int i = 0; i < prs_pkg::TAP_COUNT; i++) begin
				history_q[i] <= '0;
			end
		end else if (hist_push) begin
			history_q[0] <= cmd.sample;
			for (int i = 1; i < prs_pkg::TAP_COUNT; i++) begin
				history_q[i] <= history_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[cmd.coef_addr] <= cmd.coef_value;
		end
		coef_s1 <= coef_mem[rd_addr];
	end

	// tap walk: address and history read, multiply, accumulate
	always_ff @(posedge clk) begin
		if (run_start) begin
			row_q <= phase_q[prs_pkg::PHASE_FRAC-1 -: prs_pkg::PHASE_BITS];
			tap_q <= '0;
		end else if (issue) begin
			tap_q <= tap_q + 1'b1;
		end
		hist_s1 <= history_q[tap_q];
		prod_s2 <= coef_s1 * hist_s1;
		if (run_start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prs_pkg::ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	assign acc_shr = acc_q >>> prs_pkg::FRAC_SHIFT;

	always_comb begin
		if (acc_shr > prs_pkg::ACC_W'(prs_pkg::SAMPLE_MAX)) begin
			sat_sample = prs_pkg::SAMPLE_W'(prs_pkg::SAMPLE_MAX);
		end else if (acc_shr < prs_pkg::ACC_W'(prs_pkg::SAMPLE_MIN)) begin
			sat_sample = prs_pkg::SAMPLE_W'(prs_pkg::SAMPLE_MIN);
		end else begin
			sat_sample = prs_pkg::SAMPLE_W'(acc_shr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= sat_sample;
			out_last_q   <= out_last;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.sample_out  = out_sample_q;
	assign dout.last_of_run = out_last_q;
	assign cmd_ready        = (state_q == prs_pkg::ST_IDLE);

	assign stat.busy   = (state_q != prs_pkg::ST_IDLE);
	assign stat.in_run = (state_q == prs_pkg::ST_MAC) || (state_q == prs_pkg::ST_DRAIN);

endmodule

>>> rtl/core/polyphase_audio_resampler.sv
// channel    dir  handshake      payload
// din        in   valid/ready    opcode, sample_in, coef_phase, coef_tap, coef_value
// dout       out  valid/ready    sample_out, last_of_run
// cfg        in   cfg_we         cfg_wdata -> phase_step
//
// For each output of a push, the back end runs the phase check, walks TAP_COUNT taps through
// the one coefficient memory read port and one MAC, drains the pipeline and loads the output
// register. Coefficient writes and clears are handled in the idle state. A four-entry
// queue lets din accept items while the back end works; a full output register stalls
// the back end. Reset clears history, phase, queue and output; phase_step returns to one.
module polyphase_audio_resampler (
	input  logic                          clk,
	input  logic                          arst_n,
	prs_in_if.sink                        din,
	prs_out_if.source                     dout,
	input  logic                          cfg_we,
	input  logic [prs_pkg::PHASE_W-1:0]   cfg_wdata
);

	logic [prs_pkg::PHASE_W-1:0] phase_step_q;
	logic                        f_valid, f_ready;
	prs_pkg::cmd_t               f_cmd;
	logic                        b_valid, b_ready;
	prs_pkg::cmd_t               b_cmd;
	prs_pkg::queue_stat_t        q_stat;
	prs_pkg::back_stat_t         b_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= prs_pkg::STEP_RESET;
		end else if (cfg_we) begin
			phase_step_q <= cfg_wdata;
		end
	end

	prs_front u_front (
		.din       (din),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (f_ready)
	);

	prs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_data  (f_cmd),
		.wr_ready (f_ready),
		.rd_valid (b_valid),
		.rd_data  (b_cmd),
		.rd_ready (b_ready),
		.stat     (q_stat)
	);

	prs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (b_valid),
		.cmd        (b_cmd),
		.cmd_ready  (b_ready),
		.phase_step (phase_step_q),
		.dout       (dout),
		.stat       (b_stat)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= (prs_pkg::QUEUE_AW + 1)'(prs_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |-> !q_stat.full)
		else $error("item accepted into a full queue");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.ready && !dout.last_of_run) |=> b_stat.busy)
		else $error("run ended after an output not marked last");

	a_no_out_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.in_run |-> b_stat.busy)
		else $error("tap walk outside a run");

endmodule

>>> bench/polyphase_audio_resampler_tb.sv
`timescale 1ns / 100ps

module polyphase_audio_resampler_tb;

	localparam logic [prs_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [prs_pkg::PHASE_W-1:0] STEP_LOW  = 38'd89478485;
	localparam logic [prs_pkg::PHASE_W-1:0] STEP_HIGH = 38'd206158430208;
	localparam logic [prs_pkg::PHASE_W-1:0] STEP_CAP  = prs_pkg::PHASE_W'(64'd1 << 26);
	localparam logic [prs_pkg::PHASE_W-1:0] STEP_HALF = prs_pkg::PHASE_W'(64'd1 << 31);
	localparam logic [prs_pkg::PHASE_W-1:0] STEP_TWO  = prs_pkg::PHASE_W'(64'd1 << 33);
	localparam logic [prs_pkg::PHASE_W-1:0] STEP_FOUR = prs_pkg::PHASE_W'(64'd1 << 34);

	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 57;
	localparam int HEAVY_ITEMS    = 20;

	typedef enum logic {ROW_ITEM, ROW_STEP} row_kind_t;

	typedef struct packed {
		row_kind_t                            kind;
		logic [prs_pkg::OPCODE_W-1:0]         op;
		logic signed [prs_pkg::SAMPLE_W-1:0]  sample;
		logic [prs_pkg::COEF_PHASE_W-1:0]     ph;
		logic [prs_pkg::COEF_TAP_W-1:0]       tp;
		logic signed [prs_pkg::SAMPLE_W-1:0]  cv;
		logic [prs_pkg::PHASE_W-1:0]          step;
		logic                                 typed;
		logic signed [prs_pkg::SAMPLE_W-1:0]  typed_out;
	} stim_row_t;

	typedef struct packed {
		logic signed [prs_pkg::SAMPLE_W-1:0]  pcm;
		logic                                 last;
	} out_sample_t;

	bit                             clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [prs_pkg::PHASE_W-1:0]    cfg_wdata;

	prs_in_if  din_ch ();
	prs_out_if dout_ch ();

	polyphase_audio_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_ch),
		.dout      (dout_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predicted block state
	logic signed [prs_pkg::SAMPLE_W-1:0] hist_m [prs_pkg::TAP_COUNT];
	logic signed [prs_pkg::SAMPLE_W-1:0] coef_m [prs_pkg::COEF_DEPTH];
	logic [prs_pkg::PHASE_W-1:0]         phase_m;
	logic [prs_pkg::PHASE_W-1:0]         step_m;

	out_sample_t expected_q[$];
	stim_row_t   dir_rows[$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          quiet_cycles;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (errors < 200)
			$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic logic signed [prs_pkg::SAMPLE_W-1:0] fir_row(input int row);
		logic signed [63:0] acc;
		logic signed [63:0] c;
		logic signed [63:0] h;
		logic signed [63:0] q;
		int t;
		acc = 0;
		for (t = 0; t < prs_pkg::TAP_COUNT; t++) begin
			c = coef_m[row * prs_pkg::TAP_COUNT + t];
			h = hist_m[t];
			acc += c * h;
		end
		q = acc >>> prs_pkg::FRAC_SHIFT;
		if (q > prs_pkg::SAMPLE_MAX)
			q = prs_pkg::SAMPLE_MAX;
		if (q < prs_pkg::SAMPLE_MIN)
			q = prs_pkg::SAMPLE_MIN;
		return q[prs_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic resample_item(input logic [prs_pkg::OPCODE_W-1:0] op,
		input logic signed [prs_pkg::SAMPLE_W-1:0] sample,
		input logic [prs_pkg::COEF_PHASE_W-1:0] ph,
		input logic [prs_pkg::COEF_TAP_W-1:0] tp,
		input logic signed [prs_pkg::SAMPLE_W-1:0] cv,
		input logic typed, input logic signed [prs_pkg::SAMPLE_W-1:0] typed_out);
		int n;
		int t;
		bit have;
		logic [prs_pkg::PHASE_W:0] sum;
		out_sample_t r;
		n = 0;
		have = 0;
		r = '0;
		case (op)
		prs_pkg::OP_COEF: coef_m[{ph, tp}] = cv;
		prs_pkg::OP_CLEAR: begin
			foreach (hist_m[i])
				hist_m[i] = '0;
			phase_m = '0;
		end
		prs_pkg::OP_PUSH: begin
			for (t = prs_pkg::TAP_COUNT - 1; t > 0; t--)
				hist_m[t] = hist_m[t-1];
			hist_m[0] = sample;
			while (phase_m < prs_pkg::PHASE_UNITY && n < prs_pkg::MAX_RESULTS) begin
				// hold back one item so the final one can carry last
				if (have)
					expected_q.push_back(r);
				r.pcm = fir_row(int'(phase_m[prs_pkg::PHASE_FRAC-1 -: prs_pkg::PHASE_BITS]));
				r.last = 1'b0;
				have = 1;
				n++;
				sum = {1'b0, phase_m} + {1'b0, step_m};
				phase_m = (sum > {1'b0, prs_pkg::PHASE_MAX}) ? prs_pkg::PHASE_MAX :
					sum[prs_pkg::PHASE_W-1:0];
			end
			if (phase_m >= prs_pkg::PHASE_UNITY)
				phase_m -= prs_pkg::PHASE_UNITY;
			if (have) begin
				r.last = 1'b1;
				if (typed)
					r.pcm = typed_out;
				expected_q.push_back(r);
			end
		end
		default: ;
		endcase
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [prs_pkg::OPCODE_W-1:0] op,
		input logic signed [prs_pkg::SAMPLE_W-1:0] sample,
		input logic [prs_pkg::COEF_PHASE_W-1:0] ph,
		input logic [prs_pkg::COEF_TAP_W-1:0] tp,
		input logic signed [prs_pkg::SAMPLE_W-1:0] cv,
		input logic typed, input logic signed [prs_pkg::SAMPLE_W-1:0] typed_out);
		while ($urandom_range(99) < send_idle_pct) begin
			din_ch.valid <= 1'b0;
			@(negedge clk);
		end
		din_ch.valid      <= 1'b1;
		din_ch.opcode     <= op;
		din_ch.sample_in  <= sample;
		din_ch.coef_phase <= ph;
		din_ch.coef_tap   <= tp;
		din_ch.coef_value <= cv;
		@(posedge clk);
		while (!din_ch.ready)
			@(posedge clk);
		resample_item(op, sample, ph, tp, cv, typed, typed_out);
		@(negedge clk);
	endtask

	// drop valid, wait out every expected item and any result-free work still queued
	task automatic finish_phase();
		din_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_step(input logic [prs_pkg::PHASE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		step_m = value;
	endtask

	function automatic logic signed [prs_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
		0: return prs_pkg::SAMPLE_W'(prs_pkg::SAMPLE_MAX);
		1: return prs_pkg::SAMPLE_W'(prs_pkg::SAMPLE_MIN);
		default: return prs_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [prs_pkg::SAMPLE_W-1:0] pick_coef();
		if ($urandom_range(3) == 0)
			return prs_pkg::SAMPLE_W'($urandom);
		return prs_pkg::SAMPLE_W'($urandom_range(4095) - 2048);
	endfunction

	function automatic logic [prs_pkg::PHASE_W-1:0] rand_step(
		input logic [prs_pkg::PHASE_W-1:0] lo, input logic [prs_pkg::PHASE_W-1:0] hi);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return lo + prs_pkg::PHASE_W'(r % (64'(hi) - 64'(lo) + 64'd1));
	endfunction

	task automatic random_item();
		int r;
		logic [prs_pkg::OPCODE_W-1:0] op;
		r = $urandom_range(99);
		if (r < 84)
			op = prs_pkg::OP_PUSH;
		else if (r < 94)
			op = prs_pkg::OP_COEF;
		else if (r < 98)
			op = prs_pkg::OP_CLEAR;
		else
			op = OP_UNUSED;
		send_item(op, pick_sample(),
			prs_pkg::COEF_PHASE_W'($urandom_range(prs_pkg::PHASE_COUNT - 1)),
			prs_pkg::COEF_TAP_W'($urandom_range(prs_pkg::TAP_COUNT - 1)),
			pick_coef(), 1'b0, '0);
	endtask

	function automatic stim_row_t push_row(input logic signed [prs_pkg::SAMPLE_W-1:0] sample,
		input logic typed, input logic signed [prs_pkg::SAMPLE_W-1:0] typed_out);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.op = prs_pkg::OP_PUSH;
		row.sample = sample;
		row.typed = typed;
		row.typed_out = typed_out;
		return row;
	endfunction

	function automatic stim_row_t other_row(input logic [prs_pkg::OPCODE_W-1:0] op,
		input logic [prs_pkg::COEF_PHASE_W-1:0] ph, input logic [prs_pkg::COEF_TAP_W-1:0] tp,
		input logic signed [prs_pkg::SAMPLE_W-1:0] cv);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.op = op;
		row.sample = '1;
		row.ph = ph;
		row.tp = tp;
		row.cv = cv;
		return row;
	endfunction

	function automatic stim_row_t step_row(input logic [prs_pkg::PHASE_W-1:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_STEP;
		row.step = value;
		return row;
	endfunction

	// row 0 is a single unity tap, so early single-output pushes read off directly
	initial begin
		dir_rows.push_back(push_row(16'sd32767, 1'b1, 16'sd32766));
		dir_rows.push_back(push_row(-16'sd32768, 1'b1, -16'sd32767));
		dir_rows.push_back(other_row(prs_pkg::OP_COEF, 6'd0, 5'd0, -16'sd32768));
		dir_rows.push_back(other_row(prs_pkg::OP_COEF, 6'd0, 5'd1, -16'sd32768));
		dir_rows.push_back(push_row(-16'sd32768, 1'b1, 16'sd32767));
		dir_rows.push_back(push_row(16'sd32767, 1'b0, '0));
		dir_rows.push_back(push_row(16'sd32767, 1'b1, -16'sd32768));
		dir_rows.push_back(other_row(OP_UNUSED, '1, '1, '1));
		dir_rows.push_back(other_row(prs_pkg::OP_CLEAR, '1, '1, '1));
		dir_rows.push_back(push_row(16'sd0, 1'b1, 16'sd0));
		dir_rows.push_back(other_row(prs_pkg::OP_COEF, 6'd63, 5'd31, 16'sd32767));
		dir_rows.push_back(other_row(prs_pkg::OP_COEF, 6'd0, 5'd31, -16'sd1));
		dir_rows.push_back(step_row(STEP_LOW));
		dir_rows.push_back(push_row(16'sh1234, 1'b0, '0));
		dir_rows.push_back(push_row(-16'sd32768, 1'b0, '0));
		// step small enough that the output cap stops a run below one
		dir_rows.push_back(step_row(STEP_CAP));
		dir_rows.push_back(push_row(16'sd32767, 1'b0, '0));
		dir_rows.push_back(push_row(16'sd1, 1'b0, '0));
		dir_rows.push_back(step_row(STEP_HIGH));
		dir_rows.push_back(push_row(16'sh5a5a, 1'b0, '0));
		dir_rows.push_back(push_row(-16'sh5a5b, 1'b0, '0));
		dir_rows.push_back(push_row(16'sd7, 1'b0, '0));
		// largest step saturates the phase accumulator
		dir_rows.push_back(step_row(prs_pkg::PHASE_MAX));
		dir_rows.push_back(push_row(16'sd1000, 1'b0, '0));
		dir_rows.push_back(push_row(-16'sd1000, 1'b0, '0));
		dir_rows.push_back(other_row(prs_pkg::OP_CLEAR, '0, '0, '0));
	end

	always @(negedge clk)
		dout_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		out_sample_t head;
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item sample_out=%0d last_of_run=%0b",
					dout_ch.sample_out, dout_ch.last_of_run));
			end else begin
				head = expected_q.pop_front();
				if (dout_ch.sample_out !== head.pcm)
					report_mismatch($sformatf("sample_out %0d, expected %0d",
						dout_ch.sample_out, head.pcm));
				if (dout_ch.last_of_run !== head.last)
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
						dout_ch.last_of_run, head.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)
			|| cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no handshake for %0d cycles", quiet_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [prs_pkg::PHASE_W-1:0] step;
		int items;
		int p;
		int ph;
		int tp;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		din_ch.valid      = 1'b0;
		din_ch.opcode     = '0;
		din_ch.sample_in  = '0;
		din_ch.coef_phase = '0;
		din_ch.coef_tap   = '0;
		din_ch.coef_value = '0;
		dout_ch.ready     = 1'b0;
		errors            = 0;
		quiet_cycles      = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		foreach (hist_m[i])
			hist_m[i] = '0;
		foreach (coef_m[i])
			coef_m[i] = '0;
		phase_m = '0;
		step_m  = prs_pkg::STEP_RESET;

		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the whole table so no push ever reads an unwritten entry
		for (ph = 0; ph < prs_pkg::PHASE_COUNT; ph++)
			for (tp = 0; tp < prs_pkg::TAP_COUNT; tp++)
				send_item(prs_pkg::OP_COEF, pick_sample(), prs_pkg::COEF_PHASE_W'(ph),
					prs_pkg::COEF_TAP_W'(tp),
					(ph == 0) ? ((tp == 0) ? 16'sd32767 : 16'sd0) : pick_coef(), 1'b0, '0);

		send_idle_pct  = 10;
		recv_stall_pct = 10;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_STEP) begin
				finish_phase();
				write_step(dir_rows[i].step);
			end else begin
				send_item(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].ph, dir_rows[i].tp,
					dir_rows[i].cv, dir_rows[i].typed, dir_rows[i].typed_out);
			end
		end
		finish_phase();

		for (p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
			default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			items = PHASE_ITEMS;
			case (p)
			1: begin
				// many outputs per push: keep this phase short
				step = rand_step(STEP_LOW, STEP_HALF);
				items = HEAVY_ITEMS;
			end
			3: step = rand_step(STEP_TWO, STEP_HIGH);
			5: step = prs_pkg::STEP_RESET;
			7: step = rand_step(STEP_LOW, STEP_HIGH);
			default: step = rand_step(STEP_HALF, STEP_FOUR);
			endcase
			write_step(step);
			repeat (items)
				random_item();
			finish_phase();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
